/* rtl/core/nsd_pkg.sv */
package nsd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WDAY_W  = 3;

  // Widths of the weekday sum and of the reciprocal product.
  localparam int unsigned SUM_W  = 15;
  localparam int unsigned PROD_W = 27;
  localparam int unsigned QUO_W  = 8;

  // y / 100 equals (y * 5243) >> 19 for every 14-bit year of interest.
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [6:0] HUNDRED     = 7'd100;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd2000;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;
  localparam logic [WDAY_W-1:0]  WEEK_LEN = 3'd7;

  // Length of a month in a common year; codes that name no month give 0.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    begin
      unique case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
        4'd2:                                        len = 5'd28;
        default:                                     len = 5'd0;
      endcase
      return len;
    end
  endfunction

  // Per-month weekday offset, with January and February counted in the
  // year before.
  function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] off;
    begin
      unique case (m)
        4'd1:  off = 3'd0;
        4'd2:  off = 3'd3;
        4'd3:  off = 3'd2;
        4'd4:  off = 3'd5;
        4'd5:  off = 3'd0;
        4'd6:  off = 3'd3;
        4'd7:  off = 3'd5;
        4'd8:  off = 3'd1;
        4'd9:  off = 3'd4;
        4'd10: off = 3'd6;
        4'd11: off = 3'd2;
        4'd12: off = 3'd4;
        default: off = 3'd0;
      endcase
      return off;
    end
  endfunction

  // Remainder by 7, folding octal digits since 8 is 1 modulo 7.
  function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] s);
    logic [5:0] a;
    logic [3:0] b;
    begin
      a = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
      b = 4'(a[2:0]) + 4'(a[5:3]);
      if (b >= 4'(WEEK_LEN)) begin
        b = b - 4'(WEEK_LEN);
      end
      return b[WDAY_W-1:0];
    end
  endfunction

endpackage

/* rtl/core/next_sunday_date.sv */
// Channel   Direction  Ports                                   Handshake
// request   in         in_year_in, in_month_in, in_day_in      start & !busy
// result    out        out_year_out, out_month_out,            out_valid strobe
//                      out_day_out, out_weekday_in,
//                      out_days_added, out_bad_date
//
// The block is a four-stage pipeline: a request accepted at one edge is
// registered in stages 1, 2 and 3 and then in the output stage, which
// shows its result with out_valid high for one cycle.
// A new request can be accepted at every edge, so busy is always low.
// The stage depth is set by the reciprocal multiply for the century split.
// Reset clears only the valid bits of the stages; data registers keep junk.
// The receiver cannot stall, so results leave the last stage unconditionally.
module next_sunday_date (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [nsd_pkg::YEAR_W-1:0]      in_year_in,
  input  logic [nsd_pkg::MONTH_W-1:0]     in_month_in,
  input  logic [nsd_pkg::DAY_W-1:0]       in_day_in,
  output logic                            out_valid,
  output logic [nsd_pkg::YEAR_W-1:0]      out_year_out,
  output logic [nsd_pkg::MONTH_W-1:0]     out_month_out,
  output logic [nsd_pkg::DAY_W-1:0]       out_day_out,
  output logic [nsd_pkg::WDAY_W-1:0]      out_weekday_in,
  output logic [nsd_pkg::WDAY_W-1:0]      out_days_added,
  output logic                            out_bad_date
);

  // Stage 1: the year used for the weekday moves back by one for January
  // and February, and both that year and the real year are multiplied by
  // the reciprocal of 100.
  logic                             s1_v_r;
  logic [nsd_pkg::YEAR_W-1:0]       s1_y_r, s1_ym_r;
  logic [nsd_pkg::MONTH_W-1:0]      s1_m_r;
  logic [nsd_pkg::DAY_W-1:0]        s1_d_r;
  logic [nsd_pkg::PROD_W-1:0]       s1_pry_r, s1_prm_r;
  logic [nsd_pkg::YEAR_W-1:0]       s1_ym_nxt;

  // Stage 2: weekday sum, leap rule and date check.
  logic                             s2_v_r;
  logic [nsd_pkg::YEAR_W-1:0]       s2_y_r;
  logic [nsd_pkg::MONTH_W-1:0]      s2_m_r;
  logic [nsd_pkg::DAY_W-1:0]        s2_d_r, s2_len_r;
  logic [nsd_pkg::SUM_W-1:0]        s2_sum_r;
  logic                             s2_bad_r;
  logic [nsd_pkg::QUO_W-1:0]        qy, qym;
  logic [nsd_pkg::YEAR_W-1:0]       rem_y;
  logic                             is_leap;
  logic [nsd_pkg::DAY_W-1:0]        len_nxt;
  logic [nsd_pkg::SUM_W-1:0]        sum_nxt;
  logic                             bad_nxt;

  // Stage 3: weekday and distance to Sunday.
  logic                             s3_v_r;
  logic [nsd_pkg::YEAR_W-1:0]       s3_y_r;
  logic [nsd_pkg::MONTH_W-1:0]      s3_m_r;
  logic [nsd_pkg::DAY_W-1:0]        s3_d_r, s3_len_r;
  logic                             s3_bad_r;
  logic [nsd_pkg::WDAY_W-1:0]       s3_dow_r, s3_add_r;
  logic [nsd_pkg::WDAY_W-1:0]       dow_nxt, add_nxt;

  // Stage 4: carry of the day into the month and of the month into the year.
  logic                             out_valid_r;
  logic [nsd_pkg::YEAR_W-1:0]       out_year_r;
  logic [nsd_pkg::MONTH_W-1:0]      out_month_r;
  logic [nsd_pkg::DAY_W-1:0]        out_day_r;
  logic [nsd_pkg::WDAY_W-1:0]       out_wday_r, out_add_r;
  logic                             out_bad_r;
  logic [nsd_pkg::YEAR_W-1:0]       year_nxt;
  logic [nsd_pkg::MONTH_W-1:0]      month_nxt;
  logic [nsd_pkg::DAY_W-1:0]        day_nxt;
  logic [nsd_pkg::WDAY_W-1:0]       wday_nxt, addo_nxt;
  logic [nsd_pkg::DAY_W:0]          dsum;

  logic accept;

  // Every stage advances each cycle, so the pipe never pushes back.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign s1_ym_nxt = (in_month_in < nsd_pkg::MONTH_MAR) ?
                     in_year_in - nsd_pkg::YEAR_W'(1) : in_year_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    s1_y_r   <= in_year_in;
    s1_m_r   <= in_month_in;
    s1_d_r   <= in_day_in;
    s1_ym_r  <= s1_ym_nxt;
    s1_pry_r <= nsd_pkg::PROD_W'(in_year_in) * nsd_pkg::PROD_W'(nsd_pkg::RECIP_100);
    s1_prm_r <= nsd_pkg::PROD_W'(s1_ym_nxt) * nsd_pkg::PROD_W'(nsd_pkg::RECIP_100);
  end

  // Century quotients and the remainder of the real year by 100.
  assign qy    = s1_pry_r[nsd_pkg::RECIP_SHIFT +: nsd_pkg::QUO_W];
  assign qym   = s1_prm_r[nsd_pkg::RECIP_SHIFT +: nsd_pkg::QUO_W];
  assign rem_y = s1_y_r - nsd_pkg::YEAR_W'(qy) * nsd_pkg::YEAR_W'(nsd_pkg::HUNDRED);

  // Leap when divisible by 4 but not by 100, or divisible by 400.
  assign is_leap = ((s1_y_r[1:0] == 2'b00) && (rem_y != '0)) ||
                   ((rem_y == '0) && (qy[1:0] == 2'b00));

  always_comb begin
    len_nxt = nsd_pkg::month_len(s1_m_r);
    if ((s1_m_r == nsd_pkg::MONTH_FEB) && is_leap) begin
      len_nxt = nsd_pkg::FEB_LEAP_LEN;
    end
    bad_nxt = (s1_y_r < nsd_pkg::YEAR_MIN) || (s1_y_r > nsd_pkg::YEAR_MAX) ||
              (s1_m_r == '0) || (s1_m_r > nsd_pkg::MONTH_DEC) ||
              (s1_d_r == '0) || (s1_d_r > len_nxt);
    // Day count modulo 7 with Sunday as zero: shifted year, its quarter,
    // less its centuries, plus its quarter-centuries, month offset and day.
    sum_nxt = nsd_pkg::SUM_W'(s1_ym_r) + nsd_pkg::SUM_W'(s1_ym_r >> 2)
            - nsd_pkg::SUM_W'(qym) + nsd_pkg::SUM_W'(qym >> 2)
            + nsd_pkg::SUM_W'(nsd_pkg::month_offset(s1_m_r))
            + nsd_pkg::SUM_W'(s1_d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_y_r   <= s1_y_r;
    s2_m_r   <= s1_m_r;
    s2_d_r   <= s1_d_r;
    s2_len_r <= len_nxt;
    s2_sum_r <= sum_nxt;
    s2_bad_r <= bad_nxt;
  end

  assign dow_nxt = nsd_pkg::mod7(s2_sum_r);
  assign add_nxt = (dow_nxt == '0) ? '0 : nsd_pkg::WEEK_LEN - dow_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_y_r   <= s2_y_r;
    s3_m_r   <= s2_m_r;
    s3_d_r   <= s2_d_r;
    s3_len_r <= s2_len_r;
    s3_bad_r <= s2_bad_r;
    s3_dow_r <= dow_nxt;
    s3_add_r <= add_nxt;
  end

  // A bad date echoes the request with zero weekday and distance.
  // Otherwise the day moves forward and, past the month's end, wraps into
  // the next month; December wraps into January of the next year.
  always_comb begin
    dsum      = (nsd_pkg::DAY_W+1)'(s3_d_r) + (nsd_pkg::DAY_W+1)'(s3_add_r);
    year_nxt  = s3_y_r;
    month_nxt = s3_m_r;
    day_nxt   = s3_d_r;
    wday_nxt  = '0;
    addo_nxt  = '0;
    if (!s3_bad_r) begin
      wday_nxt = s3_dow_r;
      addo_nxt = s3_add_r;
      day_nxt  = dsum[nsd_pkg::DAY_W-1:0];
      if (dsum > (nsd_pkg::DAY_W+1)'(s3_len_r)) begin
        day_nxt = nsd_pkg::DAY_W'(dsum - (nsd_pkg::DAY_W+1)'(s3_len_r));
        if (s3_m_r == nsd_pkg::MONTH_DEC) begin
          month_nxt = nsd_pkg::MONTH_JAN;
          year_nxt  = s3_y_r + nsd_pkg::YEAR_W'(1);
        end else begin
          month_nxt = s3_m_r + nsd_pkg::MONTH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_v_r;
    end
    out_year_r  <= year_nxt;
    out_month_r <= month_nxt;
    out_day_r   <= day_nxt;
    out_wday_r  <= wday_nxt;
    out_add_r   <= addo_nxt;
    out_bad_r   <= s3_bad_r;
  end

  assign out_valid      = out_valid_r;
  assign out_year_out   = out_year_r;
  assign out_month_out  = out_month_r;
  assign out_day_out    = out_day_r;
  assign out_weekday_in = out_wday_r;
  assign out_days_added = out_add_r;
  assign out_bad_date   = out_bad_r;

endmodule
